### rtl/tmcw_pkg.sv
// tmcw_pkg: shared types and constants for the text mode console writer
// used by tmcw_front, tmcw_back and text_mode_console_writer_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tmcw_pkg;

  localparam int unsigned ROWS_DEF    = 25;
  localparam int unsigned COLUMNS_DEF = 80;

  localparam int unsigned ROW_W     = 5;
  localparam int unsigned COL_W     = 7;
  localparam int unsigned OFF_W     = 11;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned COLOR_W   = 4;
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0F20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

  typedef enum logic [1:0] {
    OP_PRINT = 2'd0,
    OP_MOVE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              in_range;
    logic              newline;
  } item_t;

endpackage

`default_nettype wire

### rtl/tmcw_front.sv
// tmcw_front: accepts input beats, classifies them and holds them in a two-entry queue
// depends on tmcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tmcw_front #(
  parameter int unsigned ROWS    = tmcw_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = tmcw_pkg::COLUMNS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [tmcw_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire  [1:0]                     in_tuser,
  input  wire                            busy_init,
  output logic                           q_valid,
  output tmcw_pkg::item_t                q_item,
  input  wire                            q_pop
);

  tmcw_pkg::item_t q_mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  tmcw_pkg::item_t new_item;

  always_comb begin
    new_item.op       = tmcw_pkg::op_t'(in_tuser);
    new_item.ch       = in_tdata[7:0];
    new_item.row      = in_tdata[12:8];
    new_item.col      = in_tdata[19:13];
    new_item.in_range = ({1'b0, in_tdata[12:8]} < 6'(ROWS)) &&
                        ({1'b0, in_tdata[19:13]} < 8'(COLUMNS));
    new_item.newline  = (in_tdata[7:0] == tmcw_pkg::NEWLINE_CHAR);
  end

  assign in_tready = (cnt_r != 2'd2) && !busy_init;
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

### rtl/tmcw_back.sv
// tmcw_back: executes queued operations on the screen store and drives the result register
// depends on tmcw_pkg
`timescale 1ns / 1ps
`default_nettype none

module tmcw_back #(
  parameter int unsigned ROWS    = tmcw_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = tmcw_pkg::COLUMNS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             q_valid,
  input  tmcw_pkg::item_t                 q_item,
  output logic                            q_pop,
  output logic                            busy_init,
  input  wire                             cfg_valid,
  input  wire  [tmcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [tmcw_pkg::COLOR_W-1:0]    cfg_data,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [tmcw_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned CELLS   = ROWS * COLUMNS;
  localparam int unsigned CELL_AW = $clog2(CELLS);
  localparam int unsigned SUM_W   = (CELL_AW > tmcw_pkg::OFF_W) ? CELL_AW : tmcw_pkg::OFF_W;

  logic [tmcw_pkg::CELL_W-1:0] mem [0:CELLS-1];
  logic [tmcw_pkg::CELL_W-1:0] rd_data_r;

  tmcw_pkg::state_t state_r, state_nxt;
  logic [CELL_AW-1:0]            addr_r, addr_nxt;
  logic                          init_r, init_nxt;
  logic [tmcw_pkg::ROW_W-1:0]    cur_row_r, cur_row_nxt;
  logic [tmcw_pkg::COL_W-1:0]    cur_col_r, cur_col_nxt;
  logic [tmcw_pkg::COLOR_W-1:0]  fg_r, fg_nxt;
  logic [tmcw_pkg::COLOR_W-1:0]  bg_r, bg_nxt;
  logic [tmcw_pkg::CHAR_W-1:0]   cell_char_r, cell_char_nxt;
  logic [tmcw_pkg::CHAR_W-1:0]   cell_attr_r, cell_attr_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [tmcw_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                        mem_we;
  logic [CELL_AW-1:0]          mem_waddr;
  logic [tmcw_pkg::CELL_W-1:0] mem_wdata;
  logic [CELL_AW-1:0]          mem_raddr;

  logic [CELL_AW-1:0] cur_idx;
  logic [CELL_AW-1:0] tgt_idx;
  logic [SUM_W-1:0]   cur_off;
  logic               row_last;
  logic               col_last;

  assign cur_idx  = CELL_AW'(cur_row_r) * CELL_AW'(COLUMNS) + CELL_AW'(cur_col_r);
  assign tgt_idx  = CELL_AW'(q_item.row) * CELL_AW'(COLUMNS) + CELL_AW'(q_item.col);
  assign cur_off  = SUM_W'(cur_idx);
  assign row_last = (cur_row_r == tmcw_pkg::ROW_W'(ROWS - 1));
  assign col_last = (cur_col_r == tmcw_pkg::COL_W'(COLUMNS - 1));

  assign busy_init  = init_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    init_nxt      = init_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    fg_nxt        = fg_r;
    bg_nxt        = bg_r;
    cell_char_nxt = cell_char_r;
    cell_attr_nxt = cell_attr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = tmcw_pkg::BLANK_CELL;
    mem_raddr     = addr_r;

    if (cfg_valid) begin
      if (cfg_index == tmcw_pkg::CFG_FG) begin
        fg_nxt = cfg_data;
      end else if (cfg_index == tmcw_pkg::CFG_BG) begin
        bg_nxt = cfg_data;
      end
    end

    unique case (state_r)
      tmcw_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop         = 1'b1;
          cell_char_nxt = '0;
          cell_attr_nxt = '0;
          state_nxt     = tmcw_pkg::ST_RESP;
          unique case (q_item.op)
            tmcw_pkg::OP_PRINT: begin
              if (q_item.newline) begin
                cur_col_nxt = '0;
                if (row_last) begin
                  addr_nxt  = '0;
                  state_nxt = tmcw_pkg::ST_SCR_RD;
                end else begin
                  cur_row_nxt = cur_row_r + tmcw_pkg::ROW_W'(1);
                end
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cur_idx;
                mem_wdata = {bg_r, fg_r, q_item.ch};
                if (col_last) begin
                  cur_col_nxt = '0;
                  if (row_last) begin
                    addr_nxt  = '0;
                    state_nxt = tmcw_pkg::ST_SCR_RD;
                  end else begin
                    cur_row_nxt = cur_row_r + tmcw_pkg::ROW_W'(1);
                  end
                end else begin
                  cur_col_nxt = cur_col_r + tmcw_pkg::COL_W'(1);
                end
              end
            end
            tmcw_pkg::OP_MOVE: begin
              if (q_item.in_range) begin
                cur_row_nxt = q_item.row;
                cur_col_nxt = q_item.col;
              end
            end
            tmcw_pkg::OP_CLEAR: begin
              addr_nxt  = '0;
              state_nxt = tmcw_pkg::ST_FILL;
            end
            tmcw_pkg::OP_READ: begin
              if (q_item.in_range) begin
                mem_raddr = tgt_idx;
                state_nxt = tmcw_pkg::ST_READ;
              end
            end
            default: state_nxt = tmcw_pkg::ST_RESP;
          endcase
        end
      end
      tmcw_pkg::ST_SCR_RD: begin
        mem_raddr = addr_r + CELL_AW'(COLUMNS);
        state_nxt = tmcw_pkg::ST_SCR_WR;
      end
      tmcw_pkg::ST_SCR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
        addr_nxt  = addr_r + CELL_AW'(1);
        if (addr_r == CELL_AW'(CELLS - COLUMNS - 1)) begin
          state_nxt = tmcw_pkg::ST_FILL;
        end else begin
          state_nxt = tmcw_pkg::ST_SCR_RD;
        end
      end
      tmcw_pkg::ST_FILL: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + CELL_AW'(1);
        if (addr_r == CELL_AW'(CELLS - 1)) begin
          init_nxt  = 1'b0;
          state_nxt = init_r ? tmcw_pkg::ST_IDLE : tmcw_pkg::ST_RESP;
        end
      end
      tmcw_pkg::ST_READ: begin
        cell_char_nxt = rd_data_r[7:0];
        cell_attr_nxt = rd_data_r[15:8];
        state_nxt     = tmcw_pkg::ST_RESP;
      end
      tmcw_pkg::ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, cell_attr_r, cell_char_r,
                           cur_off[tmcw_pkg::OFF_W-1:0], cur_col_r, cur_row_r};
          state_nxt     = tmcw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tmcw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tmcw_pkg::ST_FILL;
      addr_r      <= '0;
      init_r      <= 1'b1;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      fg_r        <= tmcw_pkg::FG_RESET;
      bg_r        <= tmcw_pkg::BG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      init_r      <= init_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      fg_r        <= fg_nxt;
      bg_r        <= bg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_char_r <= cell_char_nxt;
    cell_attr_r <= cell_attr_nxt;
    out_data_r  <= out_data_nxt;
  end

  // screen store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

endmodule

`default_nettype wire

### rtl/text_mode_console_writer_unit.sv
// text_mode_console_writer_unit: top level of the text mode console writer
// instantiates tmcw_front and tmcw_back; depends on tmcw_pkg
//
//   channel  dir  handshake              payload
//   in_      in   in_tvalid/in_tready    in_tuser operation, in_tdata char/row/col
//   out_     out  out_tvalid/out_tready  out_tdata cursor and cell fields
//   cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data (color nibble)
//
// print, move and out-of-range read: ST_IDLE then ST_RESP in the back end; in-range read: ST_IDLE, ST_READ, ST_RESP
// clear: ST_FILL blanks every cell, one store write a cycle, then ST_RESP
// scroll: ST_SCR_RD/ST_SCR_WR copy each cell up one row, then ST_FILL blanks the last row
// after reset a clearing pass over all ROWS*COLUMNS cells runs with in_tready low
// a two-entry queue and the output register let input and output stall separately
`timescale 1ns / 1ps
`default_nettype none

module text_mode_console_writer_unit #(
  parameter int unsigned ROWS    = tmcw_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = tmcw_pkg::COLUMNS_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // char_code [7:0], row [12:8], col [19:13], zero fill [23:20]
  input  wire  [tmcw_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation [1:0]
  input  wire  [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // cursor_row [4:0], cursor_col [11:5], cursor_offset [22:12],
  // cell_char [30:23], cell_attr [38:31], zero fill [39]
  output logic [tmcw_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [tmcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [tmcw_pkg::COLOR_W-1:0]    cfg_data
);

  logic            q_valid;
  logic            q_pop;
  logic            busy_init;
  tmcw_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  tmcw_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .busy_init (busy_init),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  tmcw_back #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .busy_init  (busy_init),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  localparam int unsigned CHK_W = 20;

  logic [CHK_W-1:0] chk_off;
  assign chk_off = CHK_W'(out_tdata[4:0]) * CHK_W'(COLUMNS) + CHK_W'(out_tdata[11:5]);

  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (CHK_W'(out_tdata[4:0]) < CHK_W'(ROWS)) &&
                   (CHK_W'(out_tdata[11:5]) < CHK_W'(COLUMNS)))
    else $error("reported cursor outside the screen");

  a_offset_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[22:12] == chk_off[tmcw_pkg::OFF_W-1:0])
    else $error("cursor offset does not match row and column");

  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    busy_init |-> !in_tready)
    else $error("input accepted during the clearing pass");

endmodule

`default_nettype wire
